// ----- rtl/core/csa_pkg.sv -----
// Package for the contiguous slot allocator: word types, operation codes,
// controller states and the command/status structs. No dependencies.
package csa_pkg;

  localparam int SLOTS = 256;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = IDX_W + 1;

  localparam logic [1:0] FN_BOOK    = 2'd0;
  localparam logic [1:0] FN_RELEASE = 2'd1;
  localparam logic [1:0] FN_USE     = 2'd2;
  localparam logic [1:0] FN_NONE    = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] slot;
    logic [8:0] run_length;
  } csa_in_t;

  typedef struct packed {
    logic [8:0] position;
    logic       from_released;
  } csa_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_CLR,
    ST_SH_RD,
    ST_SH_WR,
    ST_DONE
  } csa_state_t;

  typedef struct packed {
    logic load;
    logic do_release;
    logic do_use;
    logic scan_start;
    logic scan_rd;
    logic scan_ev;
    logic clr_step;
    logic sh_rd;
    logic sh_wr;
    logic shrink;
    logic res_fresh;
    logic res_zero;
    logic res_hit;
    logic out_load;
  } csa_cmd_t;

  typedef struct packed {
    logic [1:0]       func;
    logic             rel_empty;
    logic             none_in_use;
    logic             len_zero;
    logic             hit;
    logic             scan_last;
    logic             clr_last;
    logic             sh_done;
    logic             out_free;
    logic [CNT_W-1:0] rel_count;
  } csa_status_t;

endpackage

// ----- rtl/core/csa_ctrl.sv -----
// Controller of the contiguous slot allocator: sequences decode, scan,
// removal and result hand-off. Depends on csa_pkg.
module csa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  csa_pkg::csa_status_t st,
  output csa_pkg::csa_cmd_t    cmd
);
  import csa_pkg::*;

  csa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        priority if (st.func == FN_BOOK) begin
          priority if (st.rel_empty || st.none_in_use || st.len_zero) state_nxt = ST_DONE;
          else state_nxt = ST_SCAN_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN_RD: state_nxt = ST_SCAN_EV;
      ST_SCAN_EV: begin
        priority if (st.hit) state_nxt = ST_CLR;
        else if (st.scan_last) state_nxt = ST_DONE;
        else state_nxt = ST_SCAN_RD;
      end
      ST_CLR: begin
        if (st.clr_last) state_nxt = ST_SH_RD;
      end
      ST_SH_RD: begin
        if (st.sh_done) state_nxt = ST_DONE;
        else state_nxt = ST_SH_WR;
      end
      ST_SH_WR: state_nxt = ST_SH_RD;
      ST_DONE: begin
        if (st.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_EXEC: begin
        unique case (st.func)
          FN_RELEASE: cmd.do_release = 1'b1;
          FN_USE:     cmd.do_use = 1'b1;
          FN_BOOK: begin
            priority if (st.rel_empty) cmd.res_fresh = 1'b1;
            else if (st.none_in_use) cmd.res_zero = 1'b1;
            else if (st.len_zero) cmd.res_fresh = 1'b1;
            else cmd.scan_start = 1'b1;
          end
          default: ;
        endcase
      end
      ST_SCAN_RD: cmd.scan_rd = 1'b1;
      ST_SCAN_EV: begin
        cmd.scan_ev = 1'b1;
        priority if (st.hit) cmd.res_hit = 1'b1;
        else if (st.scan_last) cmd.res_fresh = 1'b1;
        else ;
      end
      ST_CLR:  cmd.clr_step = 1'b1;
      ST_SH_RD: begin
        if (st.sh_done) cmd.shrink = 1'b1;
        else cmd.sh_rd = 1'b1;
      end
      ST_SH_WR: cmd.sh_wr = 1'b1;
      ST_DONE:  cmd.out_load = st.out_free;
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/csa_dp.sv -----
// Datapath of the contiguous slot allocator: released-list memory, bitmaps,
// counters, scan registers and the output register. Depends on csa_pkg.
module csa_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  csa_pkg::csa_in_t     in_word,
  input  csa_pkg::csa_cmd_t    cmd,
  output csa_pkg::csa_status_t st,
  input  logic                 out_stall,
  output logic                 out_valid,
  output csa_pkg::csa_out_t    out_word
);
  import csa_pkg::*;

  logic [7:0]       list_mem [SLOTS];
  logic [7:0]       rd_data_r;
  csa_in_t          item_r;
  logic [SLOTS-1:0] in_use_r, in_use_nxt;
  logic [SLOTS-1:0] listed_r, listed_nxt;
  logic [CNT_W-1:0] rel_count_r, rel_count_nxt;
  logic [CNT_W-1:0] use_count_r, use_count_nxt;
  logic [CNT_W-1:0] fresh_r, fresh_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] run_r, run_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] first_r, first_nxt;
  logic [7:0]       prev_r;
  logic [8:0]       pos_r, pos_nxt;
  logic             flag_r, flag_nxt;
  logic             out_valid_r, out_valid_nxt;
  csa_out_t         out_r;

  logic [IDX_W-1:0] s_idx;
  logic [IDX_W-1:0] clr_idx;
  logic [CNT_W:0]   sh_src;
  logic [CNT_W-1:0] len;
  logic             rel_ok;

  assign s_idx   = item_r.slot[IDX_W-1:0];
  assign len     = item_r.run_length;
  assign clr_idx = first_r[IDX_W-1:0] + k_r[IDX_W-1:0];
  assign sh_src  = {1'b0, idx_r} + {1'b0, len};
  assign rel_ok  = !listed_r[s_idx] && in_use_r[s_idx] && (rel_count_r < CNT_W'(SLOTS));

  // Length of the ascending run that ends at the entry just read.
  always_comb begin
    if (idx_r != '0 && ({1'b0, prev_r} + 9'd1) == {1'b0, rd_data_r}) begin
      run_nxt = run_r + 1'b1;
    end else begin
      run_nxt = CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      rd_data_r <= list_mem[idx_r[IDX_W-1:0]];
    end else if (cmd.sh_rd) begin
      rd_data_r <= list_mem[sh_src[IDX_W-1:0]];
    end
    if (cmd.do_release && rel_ok) begin
      list_mem[rel_count_r[IDX_W-1:0]] <= item_r.slot;
    end else if (cmd.sh_wr) begin
      list_mem[idx_r[IDX_W-1:0]] <= rd_data_r;
    end
  end

  always_comb begin
    in_use_nxt    = in_use_r;
    listed_nxt    = listed_r;
    rel_count_nxt = rel_count_r;
    use_count_nxt = use_count_r;
    fresh_nxt     = fresh_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    first_nxt     = first_r;
    pos_nxt       = pos_r;
    flag_nxt      = flag_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (cmd.do_release && rel_ok) begin
      in_use_nxt[s_idx] = 1'b0;
      listed_nxt[s_idx] = 1'b1;
      rel_count_nxt     = rel_count_r + 1'b1;
      use_count_nxt     = use_count_r - 1'b1;
    end
    if (cmd.do_use) begin
      if (fresh_r == {1'b0, item_r.slot}) fresh_nxt = fresh_r + 1'b1;
      if (!in_use_r[s_idx]) use_count_nxt = use_count_r + 1'b1;
      in_use_nxt[s_idx] = 1'b1;
    end
    if (cmd.scan_start) idx_nxt = '0;
    if (cmd.scan_ev) begin
      if (run_nxt >= len) begin
        idx_nxt   = idx_r - len + 1'b1;
        first_nxt = {1'b0, rd_data_r} - len + 1'b1;
        k_nxt     = '0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
    if (cmd.clr_step) begin
      if (in_use_r[clr_idx]) use_count_nxt = use_count_r - 1'b1;
      in_use_nxt[clr_idx] = 1'b0;
      listed_nxt[clr_idx] = 1'b0;
      k_nxt = k_r + 1'b1;
    end
    if (cmd.sh_wr) idx_nxt = idx_r + 1'b1;
    if (cmd.shrink) rel_count_nxt = rel_count_r - len;
    if (cmd.res_fresh) begin
      pos_nxt  = fresh_r;
      flag_nxt = 1'b0;
    end
    if (cmd.res_zero) begin
      fresh_nxt = '0;
      pos_nxt   = '0;
      flag_nxt  = 1'b0;
    end
    if (cmd.res_hit) begin
      pos_nxt  = {1'b0, rd_data_r} - len + 1'b1;
      flag_nxt = 1'b1;
    end
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r    <= '0;
      listed_r    <= '0;
      rel_count_r <= '0;
      use_count_r <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      in_use_r    <= in_use_nxt;
      listed_r    <= listed_nxt;
      rel_count_r <= rel_count_nxt;
      use_count_r <= use_count_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_word;
    if (cmd.scan_start) run_r <= '0;
    if (cmd.scan_ev) begin
      run_r  <= run_nxt;
      prev_r <= rd_data_r;
    end
    idx_r   <= idx_nxt;
    k_r     <= k_nxt;
    first_r <= first_nxt;
    pos_r   <= pos_nxt;
    flag_r  <= flag_nxt;
    if (cmd.out_load) begin
      out_r.position      <= pos_r;
      out_r.from_released <= flag_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  assign st.func        = item_r.func;
  assign st.rel_empty   = (rel_count_r == '0);
  assign st.none_in_use = (use_count_r == '0);
  assign st.len_zero    = (len == '0);
  assign st.hit         = (run_nxt >= len);
  assign st.scan_last   = (idx_r == rel_count_r - 1'b1);
  assign st.clr_last    = (k_r == len - 1'b1);
  assign st.sh_done     = (sh_src >= {1'b0, rel_count_r});
  assign st.out_free    = !out_valid_r || !out_stall;
  assign st.rel_count   = rel_count_r;

endmodule

// ----- rtl/core/contiguous_slot_allocator.sv -----
// Top level of the contiguous slot allocator: joins the controller and the
// datapath. Depends on csa_pkg, csa_ctrl and csa_dp.
//
//   channel   direction   word type    handshake
//   in_       input       csa_in_t     in_valid / in_stall
//   out_      output      csa_out_t    out_valid / out_stall
//
// One word is worked on at a time. A release or use goes from its execute
// state straight back to idle. A book ends before the scan, ends when the
// scan finds no run, or on a hit clears run_length slots and compacts the
// released list. The scan and the compaction walk the released-list memory
// one entry at a time through its single read port. Reset clears the bitmaps
// and counters at once; no clearing pass is needed. A word may be accepted
// while a result is still held by out_stall; a finished book then waits for
// the output.
module contiguous_slot_allocator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  csa_pkg::csa_in_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output csa_pkg::csa_out_t out_word
);
  import csa_pkg::*;

  csa_cmd_t    cmd;
  csa_status_t st;

  // The controller decides what happens each cycle and holds the FSM state; the datapath holds all other state.
  csa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  csa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .st        (st),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // An accepted word makes the block raise in_stall before it can accept another.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // The released list never holds more entries than there are slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st.rel_count <= CNT_W'(SLOTS))
    else $error("released count out of range");

  // A slot granted from the released list is a real slot number.
  a_grant_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.from_released |-> out_word.position < 9'(SLOTS))
    else $error("granted slot out of range");

endmodule
